>>> hw/rtl/csve_pkg.sv
package csve_pkg;

	typedef struct packed {
		logic        command;
		logic [28:0] frame_id;
		logic [3:0]  frame_len;
		logic [63:0] frame_data;
	} in_item_t;

	typedef struct packed {
		logic [31:0] value_bits;
		logic [1:0]  val_state;
		logic        frame_accepted;
		logic        decode_error;
		logic [31:0] frames_received;
		logic [15:0] silent_ticks;
	} out_item_t;

	typedef struct packed {
		logic [28:0] match_id;
		logic [2:0]  byte_offset;
		logic [2:0]  field_kind;
		logic [15:0] stale_limit;
	} cfg_t;

	localparam logic [1:0] REG_MATCH_ID    = 2'd0;
	localparam logic [1:0] REG_BYTE_OFFSET = 2'd1;
	localparam logic [1:0] REG_FIELD_KIND  = 2'd2;
	localparam logic [1:0] REG_STALE_LIMIT = 2'd3;

	localparam logic [2:0] VT_FLOAT = 3'd0;
	localparam logic [2:0] VT_U8    = 3'd1;
	localparam logic [2:0] VT_I8    = 3'd2;
	localparam logic [2:0] VT_U16   = 3'd3;
	localparam logic [2:0] VT_I16   = 3'd4;
	localparam logic [2:0] VT_U32   = 3'd5;
	localparam logic [2:0] VT_I32   = 3'd6;

	localparam logic [1:0] ST_NONE    = 2'd0;
	localparam logic [1:0] ST_FRESH   = 2'd1;
	localparam logic [1:0] ST_STALLED = 2'd2;

	localparam logic [15:0] STALE_LIMIT_RST = 16'd5;

endpackage

>>> hw/rtl/csve_if.sv
interface csve_in_if;
	import csve_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface csve_out_if;
	import csve_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/can_sensor_value_extractor.sv
// CAN sensor value extractor.
// Input channel in_ch carries one transaction per received CAN frame
// (command 0) or per receive-timeout tick (command 1). Output channel
// out_ch returns exactly one result per input transaction: the current
// value bits, status, match/error flags, match count and silence count.
// Configuration is written through cfg_we/cfg_idx/cfg_data while idle.
// The result is valid in the cycle after input acceptance. Throughput:
// one transaction per cycle while out_ch is ready; the decode and
// float conversion sit in a single combinational pass before the result register.
// The result register holds while the receiver stalls; a new item is
// still taken when the held result is taken in the same cycle.
// Reset clears value, counters and status (no value yet) and sets the
// stale limit to 5; the block is ready straight after reset.
module can_sensor_value_extractor (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [28:0]      cfg_data,
	csve_in_if.sink          in_ch,
	csve_out_if.source       out_ch
);
	import csve_pkg::*;

	cfg_t        cfg_q;
	logic [31:0] value_q;
	logic [15:0] silence_q;
	logic [1:0]  status_q;
	logic [31:0] count_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        take;
	logic        is_match;
	logic [31:0] dec_bits;
	logic        dec_err;
	logic [31:0] n_value;
	logic [15:0] n_silence;
	logic [1:0]  n_status;
	logic [31:0] n_count;
	logic        upd;

	csve_decode u_dec (
		.frame_data  (in_ch.data.frame_data),
		.frame_len   (in_ch.data.frame_len),
		.byte_offset (cfg_q.byte_offset),
		.field_kind  (cfg_q.field_kind),
		.bits        (dec_bits),
		.err         (dec_err)
	);

	assign in_ch.ready  = !out_valid_q || out_ch.ready;
	assign take         = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	// next state for one transaction
	always_comb begin
		is_match  = !in_ch.data.command && (in_ch.data.frame_id == cfg_q.match_id);
		n_value   = value_q;
		n_silence = silence_q;
		n_status  = status_q;
		n_count   = count_q;
		upd       = 1'b0;
		if (!in_ch.data.command) begin
			if (is_match) begin
				n_value   = dec_bits;
				n_silence = 16'd0;
				n_status  = ST_FRESH;
				n_count   = count_q + 32'd1;
				upd       = 1'b1;
			end
		end else begin
			if (silence_q != 16'hFFFF) n_silence = silence_q + 16'd1;
			upd = 1'b1;
		end
		if (upd && n_silence >= cfg_q.stale_limit) n_status = ST_STALLED;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{match_id: 29'd0, byte_offset: 3'd0, field_kind: 3'd0,
				stale_limit: STALE_LIMIT_RST};
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MATCH_ID:    cfg_q.match_id    <= cfg_data;
				REG_BYTE_OFFSET: cfg_q.byte_offset <= cfg_data[2:0];
				REG_FIELD_KIND:  cfg_q.field_kind  <= cfg_data[2:0];
				REG_STALE_LIMIT: cfg_q.stale_limit <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q     <= 32'd0;
			silence_q   <= 16'd0;
			status_q    <= ST_NONE;
			count_q     <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				value_q     <= n_value;
				silence_q   <= n_silence;
				status_q    <= n_status;
				count_q     <= n_count;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.value_bits      <= n_value;
			out_q.val_state       <= n_status;
			out_q.frame_accepted  <= is_match;
			out_q.decode_error    <= is_match && dec_err;
			out_q.frames_received <= n_count;
			out_q.silent_ticks    <= n_silence;
		end
	end

endmodule

>>> hw/rtl/csve_decode.sv
// Field extraction and integer to single conversion, purely combinational
module csve_decode (
	input  logic [63:0] frame_data,
	input  logic [3:0]  frame_len,
	input  logic [2:0]  byte_offset,
	input  logic [2:0]  field_kind,
	output logic [31:0] bits,
	output logic        err
);
	import csve_pkg::*;

	logic [3:0]  len_c;
	logic [3:0]  size;
	logic        type_ok;
	logic [31:0] raw;
	logic [31:0] mag;
	logic        neg;
	logic [4:0]  top;
	logic        found;
	logic [31:0] norm;
	logic [23:0] man;
	logic        rnd;
	logic [24:0] man_r;
	logic [7:0]  expo;

	// clamp length, select field size
	always_comb begin
		len_c   = (frame_len > 4'd8) ? 4'd8 : frame_len;
		type_ok = 1'b1;
		case (field_kind)
			VT_FLOAT, VT_U32, VT_I32: size = 4'd4;
			VT_U16, VT_I16:           size = 4'd2;
			VT_U8, VT_I8:             size = 4'd1;
			default: begin
				size    = 4'd1;
				type_ok = 1'b0;
			end
		endcase
		err = !type_ok || (({1'b0, byte_offset} + size) > len_c);
	end

	// little-endian field and its magnitude
	always_comb begin
		raw = 32'(frame_data >> {byte_offset, 3'b000});
		neg = 1'b0;
		case (field_kind)
			VT_U8:  mag = {24'd0, raw[7:0]};
			VT_I8: begin
				neg = raw[7];
				mag = {24'd0, neg ? 8'(-raw[7:0]) : raw[7:0]};
				if (neg && raw[7:0] == 8'h80) mag = 32'h80;
			end
			VT_U16: mag = {16'd0, raw[15:0]};
			VT_I16: begin
				neg = raw[15];
				mag = neg ? {15'd0, 17'(17'h10000 - {1'b0, raw[15:0]})}
					: {16'd0, raw[15:0]};
			end
			VT_I32: begin
				neg = raw[31];
				mag = neg ? (32'd0 - raw) : raw;
			end
			default: mag = raw;
		endcase
	end

	// leading one search and normalise
	always_comb begin
		top   = 5'd0;
		found = 1'b0;
		for (int i = 0; i < 32; i++) begin
			if (mag[i]) top = 5'(i);
		end
		found = |mag;
		norm  = mag << (5'd31 - top);
		man   = norm[31:8];
		rnd   = norm[7] && ((|norm[6:0]) || norm[8]);
		man_r = {1'b0, man} + {24'd0, rnd};
		expo  = 8'd127 + {3'd0, top} + {7'd0, man_r[24]};
	end

	// final selection
	always_comb begin
		if (err)
			bits = 32'd0;
		else if (field_kind == VT_FLOAT)
			bits = raw;
		else if (!found)
			bits = 32'd0;
		else
			bits = {neg, expo, man_r[24] ? man_r[23:1] : man_r[22:0]};
	end

endmodule

>>> dv/csve_scoreboard.sv
package csve_tb_pkg;
	import csve_pkg::*;

	// Tracks extractor state and holds the results still owed by the block
	class csve_scoreboard;
		cfg_t        cfg;
		logic [31:0] value_q;
		logic [15:0] silence_q;
		logic [1:0]  status_q;
		logic [31:0] matches_q;
		out_item_t   pending[$];
		int          mismatches;

		function new();
			cfg = '0;
			cfg.stale_limit = STALE_LIMIT_RST;
			value_q = '0;
			silence_q = '0;
			status_q = ST_NONE;
			matches_q = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [28:0] wdata);
			case (idx)
				REG_MATCH_ID:    cfg.match_id = wdata;
				REG_BYTE_OFFSET: cfg.byte_offset = wdata[2:0];
				REG_FIELD_KIND:  cfg.field_kind = wdata[2:0];
				REG_STALE_LIMIT: cfg.stale_limit = wdata[15:0];
				default: ;
			endcase
		endfunction

		// Integer magnitude to single precision, ties to even
		static function logic [31:0] to_single(logic [31:0] mag, bit neg);
			int          msb;
			int          sh;
			logic [31:0] man;
			logic [31:0] rem;
			logic [31:0] half;
			logic [7:0]  expo;
			if (mag == 0)
				return '0;
			msb = 31;
			while (!mag[msb])
				msb--;
			expo = 8'(127 + msb);
			if (msb <= 23) begin
				man = mag << (23 - msb);
			end else begin
				sh = msb - 23;
				rem = mag & ((32'd1 << sh) - 1);
				half = 32'd1 << (sh - 1);
				man = mag >> sh;
				if (rem > half || (rem == half && man[0]))
					man++;
				if (man == 32'h0100_0000) begin
					man = man >> 1;
					expo++;
				end
			end
			return {neg, expo, man[22:0]};
		endfunction

		function bit extract(in_item_t it, output logic [31:0] bits);
			int          size;
			int          flen;
			logic [31:0] raw;
			bits = '0;
			flen = (it.frame_len > 8) ? 8 : int'(it.frame_len);
			case (cfg.field_kind)
				VT_FLOAT, VT_U32, VT_I32: size = 4;
				VT_U16, VT_I16:           size = 2;
				VT_U8, VT_I8:             size = 1;
				default:                  return 0;
			endcase
			if (int'(cfg.byte_offset) + size > flen)
				return 0;
			raw = 32'(it.frame_data >> (8 * cfg.byte_offset));
			case (cfg.field_kind)
				VT_FLOAT: bits = raw;
				VT_U8:    bits = to_single({24'd0, raw[7:0]}, 0);
				VT_I8:    bits = raw[7] ? to_single(32'h100 - raw[7:0], 1)
				                        : to_single({24'd0, raw[7:0]}, 0);
				VT_U16:   bits = to_single({16'd0, raw[15:0]}, 0);
				VT_I16:   bits = raw[15] ? to_single(32'h10000 - raw[15:0], 1)
				                         : to_single({16'd0, raw[15:0]}, 0);
				VT_U32:   bits = to_single(raw, 0);
				default:  bits = raw[31] ? to_single(-raw, 1) : to_single(raw, 0);
			endcase
			return 1;
		endfunction

		// Accepted input transaction: advance state, queue the result
		function void note_input(in_item_t it);
			out_item_t   r;
			logic [31:0] bits;
			bit          touched;
			r = '0;
			touched = 0;
			if (!it.command) begin
				if (it.frame_id == cfg.match_id) begin
					r.frame_accepted = 1;
					r.decode_error = !extract(it, bits);
					value_q = bits;
					silence_q = '0;
					status_q = ST_FRESH;
					matches_q++;
					touched = 1;
				end
			end else begin
				if (silence_q != 16'hFFFF)
					silence_q++;
				touched = 1;
			end
			if (touched && silence_q >= cfg.stale_limit)
				status_q = ST_STALLED;
			r.value_bits = value_q;
			r.val_state = status_q;
			r.frames_received = matches_q;
			r.silent_ticks = silence_q;
			pending.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got.value_bits !== want.value_bits
					|| got.val_state !== want.val_state
					|| got.frame_accepted !== want.frame_accepted
					|| got.decode_error !== want.decode_error
					|| got.frames_received !== want.frames_received
					|| got.silent_ticks !== want.silent_ticks) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected %h got %h", want, got);
			end
		endfunction
	endclass
endpackage

>>> dv/testbench.sv
module testbench;
	import csve_pkg::*;
	import csve_tb_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_idx = '0;
	logic [28:0] cfg_data = '0;
	int          cycles = 0;
	bit          calm = 0;
	int          hold_rx = 0;
	bit          done = 0;
	csve_scoreboard sb = new();

	csve_in_if  in_ch ();
	csve_out_if out_ch ();

	can_sensor_value_extractor u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always #1 clk = ~clk;

	initial begin
		in_ch.valid = 0;
		in_ch.data = '0;
		out_ch.ready = 0;
	end

	// Monitor both channels
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && in_ch.valid && in_ch.ready)
			sb.note_input(in_ch.data);
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.data);
	end

	// Receiver: random stall bursts, long hold-off on request
	always @(posedge clk) begin
		if (hold_rx > 0) begin
			out_ch.ready <= 0;
			hold_rx <= hold_rx - 1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			out_ch.ready <= 0;
			hold_rx <= $urandom_range(0, 2);
		end else begin
			out_ch.ready <= 1;
		end
	end

	always @(posedge clk) begin
		if (cycles > 200000) begin
			$display("can_sensor_value_extractor verification failed");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [28:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, val);
	endtask

	// valid stays high between back-to-back transactions
	task automatic send(in_item_t it);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	function automatic in_item_t make_frame(logic [28:0] id, logic [3:0] flen,
			logic [63:0] pl);
		in_item_t it;
		it.command = 0;
		it.frame_id = id;
		it.frame_len = flen;
		it.frame_data = pl;
		return it;
	endfunction

	function automatic in_item_t make_tick();
		in_item_t it;
		it = '0;
		it.command = 1;
		it.frame_id = 29'($urandom());
		it.frame_data = {$urandom(), $urandom()};
		return it;
	endfunction

	function automatic logic [63:0] rand_payload();
		logic [63:0] d;
		case ($urandom_range(0, 4))
			0: d = '0;
			1: d = '1;
			2: d = 64'h8080_8080_8080_8080;
			3: d = 64'h7F7F_7F7F_FFFF_FFFF;
			default: d = {$urandom(), $urandom()};
		endcase
		return d;
	endfunction

	// Random phase under the current configuration
	task automatic random_phase(int n);
		in_item_t it;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1: it = make_tick();
				2: it = make_frame(29'($urandom()), 4'($urandom()), rand_payload());
				3: it = make_frame(sb.cfg.match_id ^ (29'd1 << $urandom_range(0, 28)),
					4'($urandom()), rand_payload());
				default: it = make_frame(sb.cfg.match_id, 4'($urandom_range(0, 15)),
					rand_payload());
			endcase
			send(it);
		end
	endtask

	initial begin
		logic [28:0] ids[4];
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// Directed: reset configuration, every type, short frames, ticks
		send(make_tick());
		send(make_frame(29'd0, 4'd8, 64'h0000_0000_7FC0_0001));
		send(make_frame(29'd0, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF));
		send(make_frame(29'd1, 4'd8, '1));
		repeat (6) send(make_tick());
		drain();
		write_reg(REG_MATCH_ID, 29'h1FFF_FFFF);
		write_reg(REG_BYTE_OFFSET, 29'd7);
		write_reg(REG_FIELD_KIND, 29'(VT_I8));
		write_reg(REG_STALE_LIMIT, 29'd0);
		send(make_frame(29'h1FFF_FFFF, 4'd8, 64'h8000_0000_0000_0000));
		send(make_frame(29'h1FFF_FFFF, 4'd15, 64'h7F00_0000_0000_0000));
		send(make_frame(29'h1FFF_FFFF, 4'd7, '1));
		drain();
		write_reg(REG_BYTE_OFFSET, 29'd4);
		for (logic [2:0] vt = 1; vt != 0; vt++) begin
			write_reg(REG_FIELD_KIND, 29'(vt));
			send(make_frame(29'h1FFF_FFFF, 4'd8, 64'h8000_0001_0000_0000));
			send(make_frame(29'h1FFF_FFFF, 4'd8, 64'hFFFF_FFFF_0000_0000));
			drain();
		end
		write_reg(REG_BYTE_OFFSET, 29'd0);
		write_reg(REG_FIELD_KIND, 29'(VT_U32));
		send(make_frame(29'h1FFF_FFFF, 4'd8, 64'h0000_0000_0100_0001));
		send(make_frame(29'h1FFF_FFFF, 4'd8, 64'h0000_0000_0300_0003));
		drain();

		// Long receiver hold-off while items keep coming
		write_reg(REG_STALE_LIMIT, 29'hFFFF);
		@(negedge clk);
		hold_rx = 40;
		@(posedge clk);
		random_phase(30);
		drain();

		ids[0] = 29'd0;
		ids[1] = 29'h1FFF_FFFF;
		ids[2] = 29'h123;
		ids[3] = 29'($urandom());
		for (int ph = 0; ph < 16; ph++) begin
			write_reg(REG_MATCH_ID, ids[ph % 4]);
			write_reg(REG_BYTE_OFFSET, 29'($urandom_range(0, 7)));
			write_reg(REG_FIELD_KIND, 29'($urandom_range(0, 7)));
			write_reg(REG_STALE_LIMIT, (ph % 5 == 0) ? 29'd0 : 29'($urandom_range(1, 8)));
			if (ph >= 13)
				calm = 1;
			random_phase(50);
			drain();
		end

		repeat (5) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("can_sensor_value_extractor verification clean");
		else
			$display("can_sensor_value_extractor verification failed");
		$finish;
	end
endmodule
